// ----- rtl/oml_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oml_pkg: shared types and codes for the ordered mission list
// request and result layouts, mode and status codes, cell control structs
// ----------------------------------------------------------------------------
package oml_pkg;

  // request modes
  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_PREPEND = 2'd1;
  localparam logic [1:0] MODE_INSERT  = 2'd2;
  localparam logic [1:0] MODE_REMOVE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] mission_id;
    logic [31:0] distance;
    logic [4:0]  position;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  count;
    logic        front_valid;
    logic [15:0] front_id;
    logic [31:0] front_distance;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] distance;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic        ins_en;     // an accepted add that succeeds
    logic        rem_en;     // an accepted remove that found its key
    logic        back_only;  // remove the back entry (front did not match)
    logic [15:0] key;
    entry_t      new_ent;
  } cell_ctl_t;

  // where a cell sits relative to the list
  typedef struct packed {
    logic occupied;   // below the entry count
    logic at_ins;     // this cell takes the new entry
    logic past_ins;   // this cell takes its front neighbor
    logic past_last;  // at or behind the back entry
  } cell_pos_t;

endpackage
`default_nettype wire

// ----- rtl/ordered_mission_list_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_mission_list_unit: bounded ordered list of (id, distance) entries
// append, prepend, insert at position and remove by id over a row of cells
// ----------------------------------------------------------------------------
// usage
//   in_valid / in_stall / in_data carry one request: a mode, an id, a
//   distance and a 1-based position (insert only)
//   out_valid / out_stall / out_data carry one result per request: status,
//   entry count after the request and the front entry
//   a request is taken at a clock edge with valid high and stall low
// latency and throughput
//   the result is registered and shows in the cycle after the request is taken
//   one request per cycle unless stalled: the whole list shifts in one step,
//   each cell loads from itself, a neighbor or the new entry in the same edge
//   the remove search is a match flag rippling down the row of cells
// stall
//   while a result waits under out_stall, in_stall is raised and the list
//   holds still
// reset
//   rst_n low clears the entry count and the result valid; the list reads
//   empty at once, entry storage needs no clearing
// ----------------------------------------------------------------------------
module ordered_mission_list_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire oml_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output oml_pkg::out_t       out_data
);

  // count width holds DEPTH itself; position math needs room for count+1
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;

  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r;
  oml_pkg::out_t   out_r, out_nxt;

  logic            accept;
  logic            is_add, is_rem;
  logic            full, pos_bad, found, front_hit, back_hit;
  logic [PW-1:0]   ins_idx;
  logic [2:0]      status;
  logic            ok;
  logic [31:0]     count_wide;

  oml_pkg::cell_ctl_t ctl;
  oml_pkg::cell_pos_t cpos  [DEPTH];
  oml_pkg::entry_t    ent_q [DEPTH];
  oml_pkg::entry_t    ent_n [DEPTH];
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   is_last;
  logic [DEPTH:0]     seen;

  // output register: stall the input only while a result is held back
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_rem = (in_data.mode == oml_pkg::MODE_REMOVE);
  assign is_add = !is_rem;
  assign full   = (count_r == CW'(DEPTH));

  // slot that receives the new entry
  always_comb begin
    case (in_data.mode)
      oml_pkg::MODE_APPEND:  ins_idx = PW'(count_r);
      oml_pkg::MODE_PREPEND: ins_idx = '0;
      oml_pkg::MODE_INSERT:  ins_idx = PW'(in_data.position) - PW'(1);
      default:               ins_idx = '0;
    endcase
  end

  assign pos_bad = (in_data.mode == oml_pkg::MODE_INSERT) &&
                   ((in_data.position == 5'd0) ||
                    (PW'(in_data.position) > (PW'(count_r) + PW'(1))));

  // per-cell place in the list
  for (genvar k = 0; k < DEPTH; k++) begin : g_pos
    assign cpos[k].occupied  = (CW'(k) < count_r);
    assign cpos[k].at_ins    = (PW'(k) == ins_idx);
    assign cpos[k].past_ins  = (PW'(k) > ins_idx);
    assign cpos[k].past_last = ((CW'(k) + CW'(1)) >= count_r);
    assign is_last[k]        = ((CW'(k) + CW'(1)) == count_r);
  end

  // remove choice: front match, else back match, else first match
  assign found     = seen[DEPTH];
  assign front_hit = match[0];
  assign back_hit  = |(match & is_last);

  always_comb begin
    status = oml_pkg::ST_OK;
    if (is_rem) begin
      if (count_r == '0) begin
        status = oml_pkg::ST_EMPTY;
      end else if (!found) begin
        status = oml_pkg::ST_NOTFOUND;
      end
    end else if (pos_bad) begin
      status = oml_pkg::ST_BADPOS;
    end else if (full) begin
      status = oml_pkg::ST_FULL;
    end
  end

  assign ok = (status == oml_pkg::ST_OK);

  assign ctl.ins_en           = accept && is_add && ok;
  assign ctl.rem_en           = accept && is_rem && ok;
  assign ctl.back_only        = !front_hit && back_hit;
  assign ctl.key              = in_data.mission_id;
  assign ctl.new_ent.id       = in_data.mission_id;
  assign ctl.new_ent.distance = in_data.distance;

  // row of cells, the match flag ripples from front to back
  assign seen[0] = 1'b0;
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    oml_pkg::entry_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = ctl.new_ent;
    end else begin : g_mid
      assign left_w = ent_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_end
      assign right_w = ent_q[k];
    end else begin : g_inner
      assign right_w = ent_q[k+1];
    end
    oml_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (cpos[k]),
      .left_ent  (left_w),
      .right_ent (right_w),
      .seen_in   (seen[k]),
      .seen_out  (seen[k+1]),
      .match     (match[k]),
      .ent_q     (ent_q[k]),
      .ent_nxt   (ent_n[k])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // result built from the list as it will be after this request
  assign count_wide = 32'(count_nxt);
  always_comb begin
    out_nxt.status         = status;
    out_nxt.count          = count_wide[4:0];
    out_nxt.front_valid    = (count_nxt != '0);
    out_nxt.front_id       = out_nxt.front_valid ? ent_n[0].id : 16'd0;
    out_nxt.front_distance = out_nxt.front_valid ? ent_n[0].distance : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + CW'(1)))
    else $error("successful add did not grow the list");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem_en |=> (count_r == $past(count_r) - CW'(1)))
    else $error("successful remove did not shrink the list");

  a_front_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.front_valid == (count_r != '0)))
    else $error("front valid disagrees with entry count");

endmodule
`default_nettype wire

// ----- rtl/oml_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oml_cell: one slot of the ordered list
// holds one entry, compares its id with the remove key, shifts with neighbors
// ----------------------------------------------------------------------------
module oml_cell (
  input  wire logic               clk,
  input  wire oml_pkg::cell_ctl_t ctl,
  input  wire oml_pkg::cell_pos_t pos,
  input  wire oml_pkg::entry_t    left_ent,
  input  wire oml_pkg::entry_t    right_ent,
  input  wire logic               seen_in,
  output logic                    seen_out,
  output logic                    match,
  output oml_pkg::entry_t         ent_q,
  output oml_pkg::entry_t         ent_nxt
);

  oml_pkg::entry_t ent_r;

  assign match    = pos.occupied && (ent_r.id == ctl.key);
  assign seen_out = seen_in || match;
  assign ent_q    = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins_en) begin
      if (pos.at_ins) begin
        ent_nxt = ctl.new_ent;
      end else if (pos.past_ins) begin
        ent_nxt = left_ent;
      end
    end else if (ctl.rem_en) begin
      // close the gap from the removed slot onward
      if (ctl.back_only ? pos.past_last : seen_out) begin
        ent_nxt = right_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

// ----- test/ordered_mission_list_unit_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_mission_list_unit_tb: self-checking bench for the ordered mission list
// a short scripted sequence walks the list through empty, single entry, dup ids
// and full, then random requests drift the fill level up and down; every result
// is matched field by field against a typed result or the shadow list in the bench
// ----------------------------------------------------------------------------
module ordered_mission_list_unit_tb;

  localparam int LIST_DEPTH      = 16;
  localparam int RANDOM_REQUESTS = 1525;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 6;

  // one scripted line: a request sent n times, optionally with its result typed in
  typedef struct {
    oml_pkg::in_t  req;
    int unsigned   reps;
    bit            typed;
    oml_pkg::out_t want;
  } script_row_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  oml_pkg::in_t  in_data   = '0;
  logic          in_stall;
  logic          out_valid;
  logic          out_stall = 1'b0;
  oml_pkg::out_t out_data;

  // shadow copy of the list, updated as each request is taken
  oml_pkg::entry_t shadow_list [LIST_DEPTH];
  int unsigned     shadow_count = 0;

  // results still owed by the block, oldest first
  oml_pkg::out_t status_reports_q [$];
  script_row_t   script_q [$];

  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_hold   = 0;
  bit          tx_calm   = 1'b0;
  bit          rx_calm   = 1'b0;

  ordered_mission_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one request to the shadow list and build the result it must produce
  function automatic oml_pkg::out_t update_mission_list(oml_pkg::in_t r);
    oml_pkg::out_t rpt;
    int            slot;
    bit            grow;
    rpt        = '0;
    rpt.status = oml_pkg::ST_OK;
    slot       = -1;
    grow       = 1'b1;
    case (r.mode)
      oml_pkg::MODE_APPEND: slot = shadow_count;
      oml_pkg::MODE_PREPEND: slot = 0;
      oml_pkg::MODE_INSERT: begin
        // position check wins over the full check
        if (r.position == 0 || r.position > shadow_count + 1) begin
          rpt.status = oml_pkg::ST_BADPOS;
        end else begin
          slot = r.position - 1;
        end
      end
      default: begin
        grow = 1'b0;
        // front first, then back, then first hit counted from the front
        if (shadow_count == 0) begin
          rpt.status = oml_pkg::ST_EMPTY;
        end else if (shadow_list[0].id == r.mission_id) begin
          slot = 0;
        end else if (shadow_list[shadow_count - 1].id == r.mission_id) begin
          slot = shadow_count - 1;
        end else begin
          for (int k = 1; k < shadow_count && slot < 0; k++) begin
            if (shadow_list[k].id == r.mission_id) slot = k;
          end
          if (slot < 0) rpt.status = oml_pkg::ST_NOTFOUND;
        end
      end
    endcase
    if (grow && slot >= 0 && shadow_count >= LIST_DEPTH) begin
      rpt.status = oml_pkg::ST_FULL;
      slot       = -1;
    end
    if (slot >= 0 && grow) begin
      for (int k = shadow_count; k > slot; k--) shadow_list[k] = shadow_list[k - 1];
      shadow_list[slot].id       = r.mission_id;
      shadow_list[slot].distance = r.distance;
      shadow_count++;
    end else if (slot >= 0) begin
      for (int k = slot; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k + 1];
      shadow_count--;
    end
    rpt.count = shadow_count[4:0];
    if (shadow_count != 0) begin
      rpt.front_valid    = 1'b1;
      rpt.front_id       = shadow_list[0].id;
      rpt.front_distance = shadow_list[0].distance;
    end
    return rpt;
  endfunction

  function automatic script_row_t row(logic [1:0] m, logic [15:0] id, logic [31:0] d,
                                      logic [4:0] p, int unsigned n = 1, bit typed = 1'b0,
                                      logic [2:0] st = oml_pkg::ST_OK,
                                      logic [4:0] cnt = '0,
                                      logic fv = 1'b0, logic [15:0] fid = '0,
                                      logic [31:0] fdist = '0);
    script_row_t s;
    s.req.mode                = m;
    s.req.mission_id          = id;
    s.req.distance            = d;
    s.req.position            = p;
    s.reps                    = n;
    s.typed                   = typed;
    s.want.status             = st;
    s.want.count              = cnt;
    s.want.front_valid        = fv;
    s.want.front_id           = fid;
    s.want.front_distance     = fdist;
    return s;
  endfunction

  task automatic log_failure(input string what, input oml_pkg::out_t want,
                             input oml_pkg::out_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%s: expected st %0d cnt %0d front %0b %h %h", what, want.status,
               want.count, want.front_valid, want.front_id, want.front_distance);
      $display("  got st %0d cnt %0d front %0b %h %h", got.status, got.count,
               got.front_valid, got.front_id, got.front_distance);
    end
  endtask

  // hold off a random number of cycles, then offer the request until it is taken;
  // valid stays high across back-to-back requests so it is never dropped and raised
  // again within one step
  task automatic send_request(input oml_pkg::in_t r, input bit typed,
                              input oml_pkg::out_t want);
    int unsigned   gap;
    oml_pkg::out_t predicted;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    // taken at this edge: the shadow list moves on and the result is owed
    predicted = update_mission_list(r);
    status_reports_q.push_back(typed ? want : predicted);
  endtask

  // result side: check each taken result, then draw the stall for the next one
  always @(posedge clk) begin : result_side
    oml_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_reports_q.size() == 0) begin
          log_failure("result with no request pending", '0, out_data);
        end else begin
          want = status_reports_q.pop_front();
          if (out_data.status !== want.status || out_data.count !== want.count ||
              out_data.front_valid !== want.front_valid ||
              out_data.front_id !== want.front_id ||
              out_data.front_distance !== want.front_distance) begin
            log_failure("result mismatch", want, out_data);
          end
        end
        // occasional switch between stall-free stretches and random stalls
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 16);
      end else if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    oml_pkg::in_t r;
    int unsigned  rnd;
    int unsigned  pick;
    int unsigned  add_pct;

    // scripted requests; a typed result stands where it is plain from the request
    // empty list: remove, position zero, position far out of range
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'h0000, 32'h0, 5'd0, 1, 1'b1,
                           oml_pkg::ST_EMPTY));
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h0001, 32'h1, 5'd0, 1, 1'b1,
                           oml_pkg::ST_BADPOS));
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h0002, 32'h2, 5'd31, 1, 1'b1,
                           oml_pkg::ST_BADPOS));
    // all-ones entry in and back out: removing the only entry empties the list
    script_q.push_back(row(oml_pkg::MODE_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 1, 1'b1,
                           oml_pkg::ST_OK, 5'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'hFFFF, 32'h0, 5'd0, 1, 1'b1,
                           oml_pkg::ST_OK));
    // all-zero entry at position one, then prepend 1.0 in front of it
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h0000, 32'h0, 5'd1, 1, 1'b1,
                           oml_pkg::ST_OK, 5'd1, 1'b1, 16'h0000, 32'h0));
    script_q.push_back(row(oml_pkg::MODE_PREPEND, 16'h00AA, 32'h0001_0000, 5'd0, 1, 1'b1,
                           oml_pkg::ST_OK, 5'd2, 1'b1, 16'h00AA, 32'h0001_0000));
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'h5555, 32'h0, 5'd0, 1, 1'b1,
                           oml_pkg::ST_NOTFOUND, 5'd2, 1'b1, 16'h00AA, 32'h0001_0000));
    // duplicate ids: back match, then a match in the middle, then front over back
    script_q.push_back(row(oml_pkg::MODE_APPEND, 16'h0007, 32'h0002_8000, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_APPEND, 16'h0007, 32'h0003_0000, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h0007, 32'h0000_4000, 5'd3));
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'h0007, 32'h0, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_APPEND, 16'h0100, 32'h0010_0000, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'h0007, 32'h0, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_PREPEND, 16'h0100, 32'h0020_0000, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'h0100, 32'h0, 5'd0));
    // fill to the brim, then every kind of add against a full list
    script_q.push_back(row(oml_pkg::MODE_APPEND, 16'h8000, 32'h8000_0001, 5'd0, 12));
    script_q.push_back(row(oml_pkg::MODE_APPEND, 16'h1111, 32'h1, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_PREPEND, 16'h2222, 32'h2, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h3333, 32'h3, 5'd17));
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h4444, 32'h4, 5'd18));
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h4444, 32'h4, 5'd0));
    // back removal from full, insert at the last legal position, front removal
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'h8000, 32'h0, 5'd0));
    script_q.push_back(row(oml_pkg::MODE_INSERT, 16'h6666, 32'h6, 5'd16));
    script_q.push_back(row(oml_pkg::MODE_REMOVE, 16'h00AA, 32'h0, 5'd0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_q[i]) begin
      repeat (script_q[i].reps) send_request(script_q[i].req, script_q[i].typed,
                                             script_q[i].want);
    end

    // random part: the add share wanders so the list sweeps from empty to full;
    // most removes name an id that is held so the search paths get exercised
    add_pct = 60;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 49) == 0) add_pct = $urandom_range(15, 85);
      rnd = $urandom;
      // small id pool makes duplicates common
      r.mission_id = (rnd[3:0] < 10) ? {12'h000, rnd[7:4]} : rnd[31:16];
      rnd  = $urandom;
      pick = $urandom_range(0, 15);
      r.distance = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : rnd;
      rnd = $urandom;
      r.position = rnd[4:0];
      if ($urandom_range(0, 99) < add_pct) begin
        rnd    = $urandom_range(0, 2);
        r.mode = rnd[1:0];
        // mostly a legal position, now and then anything the field holds
        if (r.mode == oml_pkg::MODE_INSERT && $urandom_range(0, 7) != 0) begin
          rnd        = $urandom_range(1, shadow_count + 1);
          r.position = rnd[4:0];
        end
      end else begin
        r.mode = oml_pkg::MODE_REMOVE;
        pick   = $urandom_range(0, 3);
        // front id, back id or some id in between; otherwise the random one
        if (shadow_count != 0 && pick != 0) begin
          rnd = (pick == 1) ? 0 :
                (pick == 2) ? shadow_count - 1 : $urandom_range(0, shadow_count - 1);
          r.mission_id = shadow_list[rnd].id;
        end
      end
      send_request(r, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (status_reports_q.size() != 0) @(posedge clk);
    // keep clocking to catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/oml_pkg.sv
rtl/oml_cell.sv
rtl/ordered_mission_list_unit.sv
test/ordered_mission_list_unit_tb.sv
